### design/sawarq_pkg.sv
// shared types, codes and helpers for the stop-and-wait arq node
`timescale 1ns / 1ps
`default_nettype none

package sawarq_pkg;

    // retransmit queue geometry
    localparam int FIFO_DEPTH = 16;
    localparam int TAG_BITS   = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // field widths
    localparam int TIMER_W = 16;
    localparam int TIME_W  = 32;

    // small queues between the parts
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

    // request codes
    localparam logic [2:0] REQ_SRC  = 3'd0;
    localparam logic [2:0] REQ_SW   = 3'd1;
    localparam logic [2:0] REQ_NODE = 3'd2;
    localparam logic [2:0] REQ_ACK  = 3'd3;
    localparam logic [2:0] REQ_NAK  = 3'd4;
    localparam logic [2:0] REQ_TICK = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    // internal command codes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_NAK  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [TAG_BITS-1:0] packet_tag;
        logic                bit_error;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          out_kind;
        logic                out_port;
        logic [TAG_BITS-1:0] out_tag;
        logic                stamped;
        logic [TIME_W-1:0]   depart_time;
        logic                is_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [TAG_BITS-1:0] tag;
        logic                from_sw;
        logic                from_node;
        logic                bit_error;
    } cmd_t;

    // wrap-around increment of a retransmit queue pointer
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/stop_and_wait_arq_node_top.sv
// top level of the stop-and-wait arq node: register port and part wiring
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait ARQ sender with a 16-entry retransmit queue of packet tags.
// Requests (source, switch or node packet, ACK, NAK, tick) enter through a
// two-entry command queue and are carried out by a back engine that owns the
// tag memory, the retransmit timer and the tick counter; results leave
// through a two-entry result queue, one transaction each. An item that gives
// one result, or none, is done in the idle state of the engine; a node packet
// that also sends or drops, and any resend of the head packet, go on to a
// second state that pushes the second result or the registered read of the
// tag memory. The engine takes a new command only in its idle state and
// pushes one result per cycle while the result queue is not full. Request
// codes 6 and 7 are discarded at the input. The timeout register (reset 1000
// ticks) sits at byte address 0 and should be written only while idle.

module stop_and_wait_arq_node_top
    import sawarq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request queue side
    input  wire logic              push,
    output logic                   full,
    input  wire in_item_t          item,
    // result queue side
    output logic                   empty,
    input  wire logic              pop,
    output out_item_t              result,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [TIMER_W-1:0] timeout_reg;
    logic               reg_hit;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;
    logic               oq_full;
    logic               oq_push;
    out_item_t          oq_item;

    // register decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_TIMEOUT);
    assign prdata  = reg_hit ? DATA_W'(timeout_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            timeout_reg <= pwdata[TIMER_W-1:0];
        end
    end

    // request classification and command queue
    sawarq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // retransmit engine
    sawarq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .oq_full       (oq_full),
        .oq_push       (oq_push),
        .oq_item       (oq_item)
    );

    // result queue
    sawarq_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (oq_push),
        .wr_item (oq_item),
        .oq_full (oq_full),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

### design/sawarq_front.sv
// front part: accepts requests, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none

module sawarq_front
    import sawarq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  wire logic     cmd_pop
);

    localparam int QP_W = $clog2(CMDQ_DEPTH);
    localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t            q_mem [CMDQ_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    cmd_t            new_cmd;
    logic            new_ok;
    logic            wr_en;

    // classify the request into a command
    always_comb
    begin
        new_cmd.tag       = item.packet_tag;
        new_cmd.from_sw   = 1'b0;
        new_cmd.from_node = 1'b0;
        new_cmd.bit_error = item.bit_error;
        new_cmd.op        = OP_DATA;
        new_ok            = 1'b1;
        unique case (item.req_type)
            REQ_SRC:  new_cmd.op = OP_DATA;
            REQ_SW:
            begin
                new_cmd.op      = OP_DATA;
                new_cmd.from_sw = 1'b1;
            end
            REQ_NODE:
            begin
                new_cmd.op        = OP_DATA;
                new_cmd.from_node = 1'b1;
            end
            REQ_ACK:  new_cmd.op = OP_ACK;
            REQ_NAK:  new_cmd.op = OP_NAK;
            REQ_TICK: new_cmd.op = OP_TICK;
            default:  new_ok = 1'b0;
        endcase
    end

    // command queue pointers
    assign full      = (cnt_reg == QC_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign wr_en     = push && !full && new_ok;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        if (wr_en && !cmd_pop)
        begin
            cnt_next = cnt_reg + QC_W'(1);
        end
        else if (!wr_en && cmd_pop)
        begin
            cnt_next = cnt_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

### design/sawarq_back.sv
// back part: retransmit queue, timer and result generation
`timescale 1ns / 1ps
`default_nettype none

module sawarq_back
    import sawarq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [TIMER_W-1:0] timeout_ticks,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output logic                    cmd_pop,
    input  wire logic               oq_full,
    output logic                    oq_push,
    output out_item_t               oq_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PEND = 2'd1;
    localparam logic [1:0] ST_HEAD = 2'd2;

    // tag memory of the retransmit queue
    logic [TAG_BITS-1:0] mem_tag [FIFO_DEPTH];
    logic                mem_sw  [FIFO_DEPTH];

    logic [1:0]          st_reg, st_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                armed_reg, armed_next;
    logic [TIMER_W-1:0]  left_reg, left_next;
    logic [TIME_W-1:0]   tick_reg, tick_next;
    out_item_t           pend_reg, pend_next;
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic                rd_sw_reg;

    logic                wr_en;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic                q_full;
    logic                q_empty;
    out_item_t           send_item;
    out_item_t           resp_item;
    out_item_t           drop_item;
    out_item_t           head_item;

    assign q_full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign q_empty = (count_reg == '0);

    // candidate results of the current command
    always_comb
    begin
        send_item.out_kind    = KIND_DATA;
        send_item.out_port    = cmd.from_sw;
        send_item.out_tag     = cmd.tag;
        send_item.stamped     = cmd.from_sw;
        send_item.depart_time = cmd.from_sw ? tick_reg : '0;
        send_item.is_last     = 1'b1;

        resp_item.out_kind    = cmd.bit_error ? KIND_NAK : KIND_ACK;
        resp_item.out_port    = 1'b1;
        resp_item.out_tag     = '0;
        resp_item.stamped     = 1'b0;
        resp_item.depart_time = '0;
        resp_item.is_last     = !(q_full || q_empty);

        drop_item.out_kind    = KIND_DROP;
        drop_item.out_port    = 1'b0;
        drop_item.out_tag     = cmd.tag;
        drop_item.stamped     = 1'b0;
        drop_item.depart_time = '0;
        drop_item.is_last     = 1'b1;

        head_item.out_kind    = KIND_DATA;
        head_item.out_port    = rd_sw_reg;
        head_item.out_tag     = rd_tag_reg;
        head_item.stamped     = rd_sw_reg;
        head_item.depart_time = rd_sw_reg ? tick_reg : '0;
        head_item.is_last     = 1'b1;
    end

    // command execution
    always_comb
    begin
        st_next    = st_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        armed_next = armed_reg;
        left_next  = left_reg;
        tick_next  = tick_reg;
        pend_next  = pend_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        cmd_pop    = 1'b0;
        oq_push    = 1'b0;
        oq_item    = head_item;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !oq_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_DATA:
                        begin
                            if (cmd.from_node)
                            begin
                                oq_push = 1'b1;
                                oq_item = resp_item;
                                if (q_full)
                                begin
                                    pend_next = drop_item;
                                    st_next   = ST_PEND;
                                end
                                else if (q_empty)
                                begin
                                    pend_next = send_item;
                                    st_next   = ST_PEND;
                                end
                            end
                            else if (q_full)
                            begin
                                oq_push = 1'b1;
                                oq_item = drop_item;
                            end
                            else if (q_empty)
                            begin
                                oq_push = 1'b1;
                                oq_item = send_item;
                            end
                            if (!q_full)
                            begin
                                wr_en      = 1'b1;
                                tail_next  = ptr_inc(tail_reg);
                                count_next = count_reg + CNT_W'(1);
                                if (q_empty)
                                begin
                                    armed_next = 1'b1;
                                    left_next  = timeout_ticks;
                                end
                            end
                        end
                        OP_ACK:
                        begin
                            armed_next = 1'b0;
                            left_next  = '0;
                            if (!q_empty)
                            begin
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = ptr_inc(head_reg);
                                    st_next    = ST_HEAD;
                                    armed_next = 1'b1;
                                    left_next  = timeout_ticks;
                                end
                            end
                        end
                        OP_NAK:
                        begin
                            armed_next = 1'b0;
                            left_next  = '0;
                            if (!q_empty)
                            begin
                                rd_en      = 1'b1;
                                st_next    = ST_HEAD;
                                armed_next = 1'b1;
                                left_next  = timeout_ticks;
                            end
                        end
                        OP_TICK:
                        begin
                            tick_next = tick_reg + TIME_W'(1);
                            if (armed_reg)
                            begin
                                if (left_reg <= TIMER_W'(1))
                                begin
                                    armed_next = 1'b0;
                                    left_next  = '0;
                                    if (!q_empty)
                                    begin
                                        rd_en      = 1'b1;
                                        st_next    = ST_HEAD;
                                        armed_next = 1'b1;
                                        left_next  = timeout_ticks;
                                    end
                                end
                                else
                                begin
                                    left_next = left_reg - TIMER_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            ST_PEND:
            begin
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    oq_item = pend_reg;
                    st_next = ST_IDLE;
                end
            end
            ST_HEAD:
            begin
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    oq_item = head_item;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            armed_reg <= 1'b0;
            left_reg  <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            armed_reg <= armed_next;
            left_reg  <= left_next;
            tick_reg  <= tick_next;
        end
    end

    // pending second result
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // tag memory write and registered head read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_tag[tail_reg] <= cmd.tag;
            mem_sw[tail_reg]  <= cmd.from_sw;
        end
        if (rd_en)
        begin
            rd_tag_reg <= mem_tag[rd_addr];
            rd_sw_reg  <= mem_sw[rd_addr];
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("retransmit queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with unequal pointers");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_HEAD) |-> (count_reg != '0))
        else $error("head resend from an empty queue");

    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (left_reg == '0))
        else $error("disarmed timer holds a count");

    a_send_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_push && oq_item.out_kind == KIND_DATA) |=> armed_reg)
        else $error("data send without an armed timer");

endmodule

`default_nettype wire

### design/sawarq_outq.sv
// result queue between the back part and the result port
`timescale 1ns / 1ps
`default_nettype none

module sawarq_outq
    import sawarq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire out_item_t wr_item,
    output logic           oq_full,
    input  wire logic      pop,
    output logic           empty,
    output out_item_t      result
);

    localparam int QP_W = $clog2(OUTQ_DEPTH);
    localparam int QC_W = $clog2(OUTQ_DEPTH + 1);

    out_item_t       q_mem [OUTQ_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    logic            do_wr;
    logic            do_rd;

    assign oq_full = (cnt_reg == QC_W'(OUTQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign result  = q_mem[rd_ptr_reg];
    assign do_wr   = wr && !oq_full;
    assign do_rd   = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + QC_W'(1);
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire
